@@ rtl/lcadc_pkg.sv @@
// Package for the load cell converter serial reader.
// Holds command and status codes, register indexes, widths and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package lcadc_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 2;
    localparam int AVG_W     = 8;
    localparam int OFFSET_W  = 24;
    localparam int HALF_W    = 10;
    localparam int TIMEOUT_W = 32;
    localparam int SUM_W     = 32;
    localparam int READING_W = 25;
    localparam int QUOT_W    = SUM_W + 1;
    localparam int FIX_W     = SUM_W + 2;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_PDOWN = 2'd2;
    localparam logic [1:0] KIND_PUP   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_REJECT  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_B32 = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_A64 = 2'd2;

    localparam logic signed [READING_W-1:0] READING_MAX = 25'sd16777215;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic neg;
        logic fix;
    } t_dp_cmd;

    typedef struct packed {
        logic fin;
    } t_dp_sts;

endpackage

@@ rtl/lcadc_ctrl.sv @@
// Controller of the load cell converter serial reader.
// Sequences tick handling, the averaging divider and the output register valid.
// Depends on lcadc_pkg.
`timescale 1ns / 1ps

module lcadc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lcadc_pkg::t_dp_sts i_sts,
    output lcadc_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_NEG = 2'd2;
    localparam logic [1:0] ST_FIX = 2'd3;

    localparam int CW = lcadc_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] DIV_LAST = CW'(lcadc_pkg::DIV_STEPS - 1);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_ready, w_accept, w_out_fire;

    assign w_ready    = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && w_ready;
    assign w_out_fire = r_out_valid && i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.fin) begin
                        o_cmd.div_load = 1'b1;
                        n_cnt          = '0;
                        n_state        = ST_DIV;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_NEG;
                end
            end
            ST_NEG: begin
                o_cmd.neg = 1'b1;
                n_state   = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix   = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = w_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/lcadc_dp.sv @@
// Datapath of the load cell converter serial reader.
// Holds the registers, the serial read sequencer state, the bit-serial averaging
// divider and the output register. Depends on lcadc_pkg.
`timescale 1ns / 1ps

module lcadc_dp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lcadc_pkg::t_dp_cmd                     i_cmd,
    output lcadc_pkg::t_dp_sts                     o_sts,
    input  logic                                   i_cfg_we,
    input  logic [lcadc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lcadc_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [1:0]                             i_kind,
    input  logic                                   i_dout_level,
    output logic                                   o_sck_level,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic [1:0]                             o_status,
    output logic signed [lcadc_pkg::READING_W-1:0] o_reading,
    output logic                                   o_sleeping
);

    localparam int PULSE_W = $clog2(SAMPLE_BITS + 4);
    localparam int SW      = lcadc_pkg::SUM_W;
    localparam int HW      = lcadc_pkg::HALF_W;
    localparam int AW      = lcadc_pkg::AVG_W;
    localparam int OW      = lcadc_pkg::OFFSET_W;
    localparam int TW      = lcadc_pkg::TIMEOUT_W;
    localparam int RW      = lcadc_pkg::READING_W;
    localparam int QW      = lcadc_pkg::QUOT_W;
    localparam int FW      = lcadc_pkg::FIX_W;

    localparam logic [PULSE_W-1:0] PULSE_DATA = PULSE_W'(SAMPLE_BITS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    logic [lcadc_pkg::GAIN_W-1:0] r_gain;
    logic [AW-1:0]                r_avg;
    logic signed [OW-1:0]         r_off;
    logic [HW-1:0]                r_half;
    logic [TW-1:0]                r_timeout;

    logic [1:0]             r_phase, n_phase;
    logic [PULSE_W-1:0]     r_pulse, n_pulse;
    logic [HW-1:0]          r_timer, n_timer;
    logic [SAMPLE_BITS-1:0] r_shift, n_shift;
    logic [SW-1:0]          r_sum, n_sum;
    logic [AW-1:0]          r_taken, n_taken;
    logic [TW-1:0]          r_wait, n_wait;
    logic                   r_power_off, n_power_off;

    logic [SW-1:0]        r_dvd;
    logic [AW-1:0]        r_rem;
    logic                 r_neg;
    logic signed [QW-1:0] r_quot;

    logic                 r_out_sck, r_out_busy, r_out_done, r_out_sleep;
    logic [1:0]           r_out_status;
    logic signed [RW-1:0] r_out_reading;

    logic [HW-1:0]      w_hp, w_timer_inc;
    logic [AW-1:0]      w_cnt, w_taken_inc;
    logic [PULSE_W-1:0] w_extra, w_pulse_inc;
    logic [TW-1:0]      w_wait_inc;
    logic               w_sck, w_done, w_fin;
    logic [1:0]         w_status;
    logic [SW-1:0]      w_abs;
    logic [AW:0]        w_trial, w_diff;
    logic               w_ge;
    logic signed [FW-1:0] w_fix;
    logic signed [RW-1:0] w_reading;

    always_comb begin
        w_hp        = (r_half == '0) ? HW'(1) : r_half;
        w_cnt       = (r_avg == '0) ? AW'(1) : r_avg;
        w_timer_inc = r_timer + 1'b1;
        w_pulse_inc = r_pulse + 1'b1;
        w_taken_inc = r_taken + 1'b1;
        w_wait_inc  = (r_wait == {TW{1'b1}}) ? r_wait : r_wait + 1'b1;
        case (r_gain)
            lcadc_pkg::GAIN_B32: w_extra = PULSE_W'(2);
            lcadc_pkg::GAIN_A64: w_extra = PULSE_W'(3);
            default:             w_extra = PULSE_W'(1);
        endcase

        n_phase     = r_phase;
        n_pulse     = r_pulse;
        n_timer     = r_timer;
        n_shift     = r_shift;
        n_sum       = r_sum;
        n_taken     = r_taken;
        n_wait      = r_wait;
        n_power_off = r_power_off;
        w_sck       = 1'b0;
        w_done      = 1'b0;
        w_status    = lcadc_pkg::STATUS_OK;
        w_fin       = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (i_kind)
                lcadc_pkg::KIND_START: begin
                    if (r_power_off) begin
                        w_done   = 1'b1;
                        w_status = lcadc_pkg::STATUS_REJECT;
                    end else begin
                        n_phase = PH_WAIT;
                        n_pulse = '0;
                        n_timer = '0;
                        n_shift = '0;
                        n_wait  = '0;
                        n_sum   = '0;
                        n_taken = '0;
                    end
                end
                lcadc_pkg::KIND_PDOWN: n_power_off = 1'b1;
                lcadc_pkg::KIND_PUP:   n_power_off = 1'b0;
                default: ;
            endcase
        end else begin
            if (i_kind != lcadc_pkg::KIND_TICK) begin
                w_done   = 1'b1;
                w_status = lcadc_pkg::STATUS_REJECT;
            end
            case (r_phase)
                PH_WAIT: begin
                    if (!i_dout_level) begin
                        n_phase = PH_HIGH;
                        n_timer = '0;
                    end else begin
                        n_wait = w_wait_inc;
                        if (r_timeout != '0 && w_wait_inc >= r_timeout) begin
                            n_phase  = PH_IDLE;
                            w_done   = 1'b1;
                            w_status = lcadc_pkg::STATUS_TIMEOUT;
                        end
                    end
                end
                PH_HIGH: begin
                    w_sck   = 1'b1;
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= w_hp) begin
                        if (r_pulse < PULSE_DATA) begin
                            n_shift = {r_shift[SAMPLE_BITS-2:0], i_dout_level};
                        end
                        n_timer = '0;
                        n_phase = PH_LOW;
                    end
                end
                default: begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= w_hp) begin
                        n_timer = '0;
                        n_pulse = w_pulse_inc;
                        if (w_pulse_inc >= PULSE_DATA + w_extra) begin
                            n_sum   = r_sum + SW'($signed(r_shift));
                            n_taken = w_taken_inc;
                            if (w_taken_inc == '0 || w_taken_inc >= w_cnt) begin
                                n_phase  = PH_IDLE;
                                w_fin    = 1'b1;
                                w_done   = 1'b1;
                                w_status = lcadc_pkg::STATUS_OK;
                            end else begin
                                n_phase = PH_WAIT;
                                n_pulse = '0;
                                n_timer = '0;
                                n_shift = '0;
                                n_wait  = '0;
                            end
                        end else begin
                            n_phase = PH_HIGH;
                        end
                    end
                end
            endcase
        end

        if (n_phase == PH_IDLE && n_power_off) begin
            w_sck = 1'b1;
        end
    end

    assign o_sts.fin = w_fin;

    assign w_abs   = n_sum[SW-1] ? (~n_sum + 1'b1) : n_sum;
    assign w_trial = {r_rem, r_dvd[SW-1]};
    assign w_ge    = (w_trial >= {1'b0, w_cnt});
    assign w_diff  = w_trial - {1'b0, w_cnt};
    assign w_fix   = FW'(r_quot) - FW'(r_off);

    always_comb begin
        if (w_fix > FW'(lcadc_pkg::READING_MAX)) begin
            w_reading = lcadc_pkg::READING_MAX;
        end else if (w_fix < -FW'(lcadc_pkg::READING_MAX)) begin
            w_reading = -lcadc_pkg::READING_MAX;
        end else begin
            w_reading = w_fix[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= '0;
            r_avg     <= AW'(1);
            r_off     <= '0;
            r_half    <= HW'(1);
            r_timeout <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcadc_pkg::CFG_GAIN:    r_gain    <= i_cfg_data[lcadc_pkg::GAIN_W-1:0];
                lcadc_pkg::CFG_AVG:     r_avg     <= i_cfg_data[AW-1:0];
                lcadc_pkg::CFG_OFFSET:  r_off     <= $signed(i_cfg_data[OW-1:0]);
                lcadc_pkg::CFG_HALF:    r_half    <= i_cfg_data[HW-1:0];
                lcadc_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pulse     <= '0;
            r_timer     <= '0;
            r_shift     <= '0;
            r_sum       <= '0;
            r_taken     <= '0;
            r_wait      <= '0;
            r_power_off <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase     <= n_phase;
            r_pulse     <= n_pulse;
            r_timer     <= n_timer;
            r_shift     <= n_shift;
            r_sum       <= n_sum;
            r_taken     <= n_taken;
            r_wait      <= n_wait;
            r_power_off <= n_power_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= w_abs;
            r_rem <= '0;
            r_neg <= n_sum[SW-1];
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[SW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[AW-1:0] : w_trial[AW-1:0];
        end
        if (i_cmd.neg) begin
            r_quot <= r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_sck     <= w_sck;
            r_out_busy    <= (n_phase != PH_IDLE);
            r_out_done    <= w_done;
            r_out_status  <= w_status;
            r_out_sleep   <= n_power_off;
            r_out_reading <= '0;
        end else if (i_cmd.fix) begin
            r_out_reading <= w_reading;
        end
    end

    assign o_sck_level = r_out_sck;
    assign o_busy_res  = r_out_busy;
    assign o_done_res  = r_out_done;
    assign o_status    = r_out_status;
    assign o_reading   = r_out_reading;
    assign o_sleeping  = r_out_sleep;

endmodule

@@ rtl/load_cell_adc_serial_reader_core.sv @@
// Interface master for a two-wire bridge converter with a serial sample output.
// Each input beat is one tick of the serial clock sequencer with a command and the
// data line level; each tick gives one result beat. An ordinary tick goes to the
// output register directly, and the next tick is accepted once the output register
// is empty or is being read in the same cycle. After the tick that completes an
// averaged read come 32 steps of the one-bit-per-cycle averaging divider, the
// sign step and the offset subtraction and saturation step, taking no tick. There
// is no clearing pass after reset. Depends on lcadc_pkg, lcadc_ctrl and lcadc_dp.
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_kind,
    input  logic                                   i_dout_level,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_sck_level,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic [1:0]                             o_status,
    output logic signed [lcadc_pkg::READING_W-1:0] o_reading,
    output logic                                   o_sleeping,
    input  logic                                   i_cfg_we,
    input  logic [lcadc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lcadc_pkg::CFG_W-1:0]            i_cfg_data
);

    lcadc_pkg::t_dp_cmd w_cmd;
    lcadc_pkg::t_dp_sts w_sts;

    lcadc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lcadc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_dout_level (i_dout_level),
        .o_sck_level  (o_sck_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_reading    (o_reading),
        .o_sleeping   (o_sleeping)
    );

    a_reading_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading != '0) |-> (o_done_res && o_status == lcadc_pkg::STATUS_OK))
        else $error("Non-zero reading without a successful finish.");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != lcadc_pkg::STATUS_OK) |-> o_done_res)
        else $error("Error status without done.");

    a_sleep_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res && o_sleeping) |-> o_sck_level)
        else $error("Serial clock low while powered down and idle.");

    a_divide_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_sts.fin) |=> (!o_out_valid && !o_in_ready))
        else $error("Result shown or input taken before the average is ready.");

endmodule
